// File: rtl/pmad_pkg.sv
// ----------------------------------------------------------------------------
// pmad_pkg
// Shared constants, codes and types of the page map address decoder.
// ----------------------------------------------------------------------------
package pmad_pkg;

	// table geometry
	localparam int PAGE_ENTRIES  = 256;
	localparam int HANDLER_SLOTS = 32;
	localparam int PAGE_AW       = $clog2(PAGE_ENTRIES);
	localparam int PAGE_SHIFT    = 24;
	localparam logic [31:0] PAGE_STEP = 32'h0100_0000;

	// command codes
	localparam logic [1:0] CMD_ACCESS     = 2'd0;
	localparam logic [1:0] CMD_MAP_HANDLR = 2'd1;
	localparam logic [1:0] CMD_MAP_BLOCK  = 2'd2;
	localparam logic [1:0] CMD_MIRROR     = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_RANGE = 2'd1;
	localparam logic [1:0] ST_BAD_MASK  = 2'd2;
	localparam logic [1:0] ST_BAD_BASE  = 2'd3;

	// access width codes
	localparam logic [1:0] SZ_BYTE   = 2'd0;
	localparam logic [1:0] SZ_HALF   = 2'd1;
	localparam logic [1:0] SZ_WORD   = 2'd2;
	localparam logic [1:0] SZ_DOUBLE = 2'd3;

	// route codes
	localparam logic ROUTE_HANDLER = 1'b0;
	localparam logic ROUTE_DIRECT  = 1'b1;

	// configuration register indexes
	localparam int CFG_IW = 1;
	localparam logic [CFG_IW-1:0] CFG_BIG_ENDIAN = 1'd0;
	localparam logic [CFG_IW-1:0] CFG_SPLIT_64   = 1'd1;

	// what the output register loads
	localparam logic [1:0] EMIT_NONE   = 2'd0;
	localparam logic [1:0] EMIT_BEAT0  = 2'd1;
	localparam logic [1:0] EMIT_BEAT1  = 2'd2;
	localparam logic [1:0] EMIT_STATUS = 2'd3;

	// one page table entry
	typedef struct packed {
		logic        blk;
		logic [31:0] base;
		logic [4:0]  shift;
		logic [4:0]  hnd;
	} pmad_entry_t;

	// controller to datapath
	typedef struct packed {
		logic       accept;
		logic       rd_port;
		logic       check;
		logic       fill_wr;
		logic       mir_wr;
		logic       step;
		logic [1:0] emit;
	} pmad_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] command;
		logic       error;
		logic       fill_end;
		logic       mir_end;
		logic       two_beats;
	} pmad_stat_t;

endpackage

// File: rtl/page_map_address_decoder_unit.sv
// Access: first word after the page table read and the result register, a second word (split 64-bit) in the next cycle;
// a new access is taken only once the previous one is done (one page table read port).
// Map range writes the pages in turn; mirror of N pages: read, then write a page, for each page.
// Results carry a one-cycle strobe; the receiver cannot stall them.
// Reset: asynchronous; every page maps handler 0, big_endian_host=1, split_direct_64=0,
// done at once by per-page valid flops, so the block is ready in the first cycle.
// ----------------------------------------------------------------------------
// page_map_address_decoder_unit
// Page table decoder: routes accesses to handlers or direct blocks and
// services map range and mirror commands.
// ----------------------------------------------------------------------------
module page_map_address_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [31:0] address,
	input  logic [1:0]  access_size,
	input  logic        is_write,
	input  logic [63:0] write_data,
	input  logic [7:0]  first_page,
	input  logic [7:0]  last_page,
	input  logic [8:0]  page_count,
	input  logic [7:0]  dest_page,
	input  logic [4:0]  handler_number,
	input  logic [31:0] block_base,
	input  logic [31:0] address_mask,
	input  logic        cfg_write,
	input  logic [pmad_pkg::CFG_IW-1:0] cfg_index,
	input  logic        cfg_data,
	output logic        result_strobe,
	output logic [1:0]  status,
	output logic        route,
	output logic [4:0]  handler_out,
	output logic [31:0] target_address,
	output logic [1:0]  beat_size,
	output logic [63:0] beat_data,
	output logic        beat_write,
	output logic        last
);

	pmad_pkg::pmad_cmd_t  cmd;
	pmad_pkg::pmad_stat_t stat;

	// sequencer
	pmad_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.command(command),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// table, checks and routing
	pmad_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.command       (command),
		.address       (address),
		.access_size   (access_size),
		.is_write      (is_write),
		.write_data    (write_data),
		.first_page    (first_page),
		.last_page     (last_page),
		.page_count    (page_count),
		.dest_page     (dest_page),
		.handler_number(handler_number),
		.block_base    (block_base),
		.address_mask  (address_mask),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result_strobe (result_strobe),
		.status        (status),
		.route         (route),
		.handler_out   (handler_out),
		.target_address(target_address),
		.beat_size     (beat_size),
		.beat_data     (beat_data),
		.beat_write    (beat_write),
		.last          (last)
	);

endmodule

// File: rtl/pmad_ram.sv
// ----------------------------------------------------------------------------
// pmad_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pmad_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/pmad_ctrl.sv
// ----------------------------------------------------------------------------
// pmad_ctrl
// Sequencer for accesses, range fills and mirror copies.
// ----------------------------------------------------------------------------
module pmad_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          command,
	input  pmad_pkg::pmad_stat_t stat,
	output pmad_pkg::pmad_cmd_t  cmd,
	output logic                busy
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_LOOKUP = 3'd1;
	localparam logic [2:0] S_BEAT1  = 3'd2;
	localparam logic [2:0] S_CHECK  = 3'd3;
	localparam logic [2:0] S_FILL   = 3'd4;
	localparam logic [2:0] S_MIR_RD = 3'd5;
	localparam logic [2:0] S_MIR_WR = 3'd6;
	localparam logic [2:0] S_REPORT = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.emit = pmad_pkg::EMIT_NONE;
		unique case (state_q)
			S_IDLE: begin
				cmd.rd_port = 1'b1;
				if (start) begin
					cmd.accept = 1'b1;
					state_d = (command == pmad_pkg::CMD_ACCESS) ? S_LOOKUP : S_CHECK;
				end
			end
			S_LOOKUP: begin
				cmd.emit = pmad_pkg::EMIT_BEAT0;
				state_d  = stat.two_beats ? S_BEAT1 : S_IDLE;
			end
			S_BEAT1: begin
				cmd.emit = pmad_pkg::EMIT_BEAT1;
				state_d  = S_IDLE;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (stat.error) begin
					state_d = S_REPORT;
				end else if (stat.command == pmad_pkg::CMD_MIRROR) begin
					state_d = S_MIR_RD;
				end else begin
					state_d = S_FILL;
				end
			end
			S_FILL: begin
				cmd.fill_wr = 1'b1;
				cmd.step    = 1'b1;
				state_d     = stat.fill_end ? S_REPORT : S_FILL;
			end
			S_MIR_RD: begin
				state_d = S_MIR_WR;
			end
			S_MIR_WR: begin
				cmd.mir_wr = 1'b1;
				cmd.step   = 1'b1;
				state_d    = stat.mir_end ? S_REPORT : S_MIR_RD;
			end
			S_REPORT: begin
				cmd.emit = pmad_pkg::EMIT_STATUS;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// File: rtl/pmad_dp.sv
// ----------------------------------------------------------------------------
// pmad_dp
// Datapath: command latch, range checks, page table with valid bits,
// address routing and the result register.
// ----------------------------------------------------------------------------
module pmad_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  pmad_pkg::pmad_cmd_t  cmd,
	output pmad_pkg::pmad_stat_t stat,
	input  logic [1:0]          command,
	input  logic [31:0]         address,
	input  logic [1:0]          access_size,
	input  logic                is_write,
	input  logic [63:0]         write_data,
	input  logic [7:0]          first_page,
	input  logic [7:0]          last_page,
	input  logic [8:0]          page_count,
	input  logic [7:0]          dest_page,
	input  logic [4:0]          handler_number,
	input  logic [31:0]         block_base,
	input  logic [31:0]         address_mask,
	input  logic                cfg_write,
	input  logic [pmad_pkg::CFG_IW-1:0] cfg_index,
	input  logic                cfg_data,
	output logic                result_strobe,
	output logic [1:0]          status,
	output logic                route,
	output logic [4:0]          handler_out,
	output logic [31:0]         target_address,
	output logic [1:0]          beat_size,
	output logic [63:0]         beat_data,
	output logic                beat_write,
	output logic                last
);

	localparam int AW = pmad_pkg::PAGE_AW;
	localparam int EW = $bits(pmad_pkg::pmad_entry_t);

	// keep only the bits of the beat width
	function automatic logic [63:0] trunc_data(input logic [63:0] d, input logic [1:0] sz);
		logic [63:0] r;
		r = d;
		unique case (sz)
			pmad_pkg::SZ_BYTE:   r = {56'd0, d[7:0]};
			pmad_pkg::SZ_HALF:   r = {48'd0, d[15:0]};
			pmad_pkg::SZ_WORD:   r = {32'd0, d[31:0]};
			pmad_pkg::SZ_DOUBLE: r = d;
			default:             r = d;
		endcase
		return r;
	endfunction

	// shift of a low-ones mask: index of the top one, inverted
	function automatic logic [4:0] mask_to_shift(input logic [31:0] m);
		logic [31:0] top;
		logic [4:0]  idx;
		top = m & ~(m >> 1);
		idx = '0;
		for (int i = 0; i < 32; i++) begin
			if (top[i]) begin
				idx = idx | 5'(i);
			end
		end
		return ~idx;
	endfunction

	// configuration registers
	logic big_endian_q;
	logic split_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b1;
			split_q      <= 1'b0;
		end else if (cfg_write) begin
			if (cfg_index == pmad_pkg::CFG_BIG_ENDIAN) begin
				big_endian_q <= cfg_data;
			end
			if (cfg_index == pmad_pkg::CFG_SPLIT_64) begin
				split_q <= cfg_data;
			end
		end
	end

	// input word latch
	logic [1:0]  cmd_q;
	logic [31:0] addr_q;
	logic [1:0]  size_q;
	logic        wr_q;
	logic [63:0] wdata_q;
	logic [7:0]  first_q;
	logic [7:0]  last_q;
	logic [8:0]  count_q;
	logic [7:0]  dest_q;
	logic [4:0]  hnd_q;
	logic [31:0] base_q;
	logic [31:0] mask_q;
	logic        page_in_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q     <= command;
			addr_q    <= address;
			size_q    <= access_size;
			wr_q      <= is_write;
			wdata_q   <= is_write ? write_data : 64'd0;
			first_q   <= first_page;
			last_q    <= last_page;
			count_q   <= page_count;
			dest_q    <= dest_page;
			hnd_q     <= handler_number;
			base_q    <= block_base;
			mask_q    <= address_mask;
			page_in_q <= {1'b0, address[31:pmad_pkg::PAGE_SHIFT]}
				< 9'(pmad_pkg::PAGE_ENTRIES);
		end
	end

	// range, base and mask checks
	logic [9:0]  mir_end_w;
	logic        map_range_bad;
	logic        mir_range_bad;
	logic        base_bad;
	logic        mask_bad;
	logic [1:0]  status_c;

	always_comb begin
		mir_end_w = {2'b0, first_q} + {1'b0, count_q} - 10'd1;
		map_range_bad = (first_q > last_q)
			|| ({1'b0, last_q} >= 9'(pmad_pkg::PAGE_ENTRIES));
		mir_range_bad = (count_q == 9'd0)
			|| ({1'b0, first_q} >= 9'(pmad_pkg::PAGE_ENTRIES))
			|| ({1'b0, dest_q} >= 9'(pmad_pkg::PAGE_ENTRIES))
			|| (mir_end_w >= 10'(pmad_pkg::PAGE_ENTRIES))
			|| (({2'b0, dest_q} >= {2'b0, first_q}) && ({2'b0, dest_q} <= mir_end_w));
		base_bad = (base_q == 32'd0) || (base_q[7:0] != 8'd0);
		mask_bad = (mask_q == 32'd0) || ((mask_q & (mask_q + 32'd1)) != 32'd0);
		status_c = pmad_pkg::ST_OK;
		unique case (cmd_q)
			pmad_pkg::CMD_MAP_HANDLR: begin
				if (map_range_bad || ({1'b0, hnd_q} >= 6'(pmad_pkg::HANDLER_SLOTS))) begin
					status_c = pmad_pkg::ST_BAD_RANGE;
				end
			end
			pmad_pkg::CMD_MAP_BLOCK: begin
				if (map_range_bad) begin
					status_c = pmad_pkg::ST_BAD_RANGE;
				end else if (base_bad) begin
					status_c = pmad_pkg::ST_BAD_BASE;
				end else if (mask_bad) begin
					status_c = pmad_pkg::ST_BAD_MASK;
				end
			end
			pmad_pkg::CMD_MIRROR: begin
				if (mir_range_bad) begin
					status_c = pmad_pkg::ST_BAD_RANGE;
				end
			end
			pmad_pkg::CMD_ACCESS: begin
				status_c = pmad_pkg::ST_OK;
			end
			default: begin
				status_c = pmad_pkg::ST_OK;
			end
		endcase
	end

	// walk pointers for fills and mirrors
	logic [1:0]  status_q;
	logic [4:0]  shift_q;
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] dst_q;
	logic [8:0]  cnt_q;
	logic [31:0] run_base_q;

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			status_q   <= status_c;
			shift_q    <= mask_to_shift(mask_q);
			ptr_q      <= first_q[AW-1:0];
			dst_q      <= dest_q[AW-1:0];
			cnt_q      <= count_q;
			run_base_q <= base_q;
		end else if (cmd.step) begin
			ptr_q      <= ptr_q + 1'b1;
			dst_q      <= (dst_q == AW'(pmad_pkg::PAGE_ENTRIES - 1)) ? '0 : dst_q + 1'b1;
			cnt_q      <= cnt_q - 9'd1;
			run_base_q <= run_base_q + pmad_pkg::PAGE_STEP;
		end
	end

	// page table and valid bits
	logic [AW-1:0]         raddr;
	logic [AW-1:0]         waddr;
	logic                  we;
	pmad_pkg::pmad_entry_t wentry;
	pmad_pkg::pmad_entry_t rentry;
	logic [EW-1:0]         rdata;
	logic [pmad_pkg::PAGE_ENTRIES-1:0] valid_q;
	logic                  rd_valid_q;

	assign raddr = cmd.rd_port ? address[pmad_pkg::PAGE_SHIFT +: AW] : ptr_q;
	assign we    = cmd.fill_wr || cmd.mir_wr;
	assign waddr = cmd.mir_wr ? dst_q : ptr_q;
	assign rentry = rd_valid_q ? pmad_pkg::pmad_entry_t'(rdata) : '0;

	// entry to write
	always_comb begin
		wentry = '0;
		if (cmd.mir_wr) begin
			wentry = rentry;
		end else if (cmd_q == pmad_pkg::CMD_MAP_BLOCK) begin
			wentry.blk   = 1'b1;
			wentry.base  = run_base_q;
			wentry.shift = shift_q;
		end else begin
			wentry.hnd = hnd_q;
		end
	end

	pmad_ram #(
		.WIDTH(EW),
		.DEPTH(pmad_pkg::PAGE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wentry),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[raddr];
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	// access routing
	pmad_pkg::pmad_entry_t ent;
	logic        two_beats;
	logic [1:0]  eff_size;
	logic [31:0] offset;
	logic [31:0] phys;

	always_comb begin
		ent       = page_in_q ? rentry : '0;
		two_beats = (size_q == pmad_pkg::SZ_DOUBLE) && (!ent.blk || split_q);
		eff_size  = two_beats ? pmad_pkg::SZ_WORD : size_q;
		offset    = addr_q & (32'hFFFF_FFFF >> ent.shift);
		if (big_endian_q && (size_q == pmad_pkg::SZ_BYTE)) begin
			offset[1:0] = offset[1:0] ^ 2'b11;
		end else if (big_endian_q && (size_q == pmad_pkg::SZ_HALF)) begin
			offset[1:0] = offset[1:0] ^ 2'b10;
		end
		phys = ent.base + offset;
	end

	// result register
	logic        strobe_q;
	logic [1:0]  status_o_q;
	logic        route_q;
	logic [4:0]  hnd_o_q;
	logic [31:0] taddr_q;
	logic [1:0]  bsize_q;
	logic [63:0] bdata_q;
	logic        bwrite_q;
	logic        blast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (cmd.emit != pmad_pkg::EMIT_NONE);
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.emit)
			pmad_pkg::EMIT_BEAT0: begin
				status_o_q <= pmad_pkg::ST_OK;
				route_q    <= ent.blk ? pmad_pkg::ROUTE_DIRECT : pmad_pkg::ROUTE_HANDLER;
				hnd_o_q    <= ent.blk ? 5'd0 : ent.hnd;
				taddr_q    <= ent.blk ? phys : addr_q;
				bsize_q    <= eff_size;
				bdata_q    <= trunc_data(wdata_q, eff_size);
				bwrite_q   <= wr_q;
				blast_q    <= !two_beats;
			end
			pmad_pkg::EMIT_BEAT1: begin
				taddr_q  <= taddr_q + 32'd4;
				bsize_q  <= pmad_pkg::SZ_WORD;
				bdata_q  <= {32'd0, wdata_q[63:32]};
				blast_q  <= 1'b1;
			end
			pmad_pkg::EMIT_STATUS: begin
				status_o_q <= status_q;
				route_q    <= pmad_pkg::ROUTE_HANDLER;
				hnd_o_q    <= 5'd0;
				taddr_q    <= 32'd0;
				bsize_q    <= pmad_pkg::SZ_BYTE;
				bdata_q    <= 64'd0;
				bwrite_q   <= 1'b0;
				blast_q    <= 1'b1;
			end
			pmad_pkg::EMIT_NONE: begin
			end
			default: begin
			end
		endcase
	end

	// status back to the controller
	assign stat.command   = cmd_q;
	assign stat.error     = (status_c != pmad_pkg::ST_OK);
	assign stat.fill_end  = (ptr_q == last_q[AW-1:0]);
	assign stat.mir_end   = (cnt_q == 9'd1);
	assign stat.two_beats = two_beats;

	assign result_strobe  = strobe_q;
	assign status         = status_o_q;
	assign route          = route_q;
	assign handler_out    = hnd_o_q;
	assign target_address = taddr_q;
	assign beat_size      = bsize_q;
	assign beat_data      = bdata_q;
	assign beat_write     = bwrite_q;
	assign last           = blast_q;

endmodule

// File: rtl/pmad_chk.sv
// ----------------------------------------------------------------------------
// pmad_chk
// Port-level checks of the page map address decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pmad_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        result_strobe,
	input logic [1:0]  status,
	input logic        route,
	input logic [1:0]  beat_size,
	input logic        last
);

	// an accepted word always occupies the block
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted word");

	// the second beat follows the first without a gap
	a_second_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !last) |=> (result_strobe && last))
		else $error("second beat missing");

	// a split beat is always a 32-bit word
	a_split_word: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !last) |-> (beat_size == pmad_pkg::SZ_WORD))
		else $error("first of two beats is not a word");

	// an error report is a single, non-routed result
	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && (status != pmad_pkg::ST_OK)) |->
		(last && (route == pmad_pkg::ROUTE_HANDLER)))
		else $error("error status on a routed or non-final result");

	// results only come from work in progress
	a_strobe_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result without an accepted word");

endmodule

bind page_map_address_decoder_unit pmad_chk u_pmad_chk (.*);

// File: tb/pmad_checker.sv
// ----------------------------------------------------------------------------
// pmad_checker
// Watches the command and result channels of the page map address decoder,
// keeps its own page table and configuration, predicts every result word
// and compares each word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module pmad_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  command,
	input  logic [31:0] address,
	input  logic [1:0]  access_size,
	input  logic        is_write,
	input  logic [63:0] write_data,
	input  logic [7:0]  first_page,
	input  logic [7:0]  last_page,
	input  logic [8:0]  page_count,
	input  logic [7:0]  dest_page,
	input  logic [4:0]  handler_number,
	input  logic [31:0] block_base,
	input  logic [31:0] address_mask,
	input  logic        cfg_write,
	input  logic [pmad_pkg::CFG_IW-1:0] cfg_index,
	input  logic        cfg_data,
	input  logic        result_strobe,
	input  logic [1:0]  status,
	input  logic        route,
	input  logic [4:0]  handler_out,
	input  logic [31:0] target_address,
	input  logic [1:0]  beat_size,
	input  logic [63:0] beat_data,
	input  logic        beat_write,
	input  logic        last,
	output int          mismatches,
	output int          outstanding,
	output int          words_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import pmad_pkg::*;

	// one predicted result word
	typedef struct {
		logic [1:0]  status;
		logic        route;
		logic [4:0]  hnd;
		logic [31:0] addr;
		logic [1:0]  size;
		logic [63:0] data;
		logic        wr;
		logic        last;
	} word_t;

	word_t word_q[$];

	// shadow page table and configuration
	logic        map_blk   [PAGE_ENTRIES];
	logic [31:0] map_base  [PAGE_ENTRIES];
	logic [4:0]  map_shift [PAGE_ENTRIES];
	logic [4:0]  map_hnd   [PAGE_ENTRIES];
	logic        be_host;
	logic        split64;

	task automatic push_word(input logic [1:0] st, input logic rt, input logic [4:0] h,
			input logic [31:0] a, input logic [1:0] sz, input logic [63:0] d,
			input logic wr, input logic lst);
		word_t w;
		w.status = st;
		w.route  = rt;
		w.hnd    = h;
		w.addr   = a;
		w.size   = sz;
		w.data   = d;
		w.wr     = wr;
		w.last   = lst;
		word_q.push_back(w);
	endtask

	// write data cut to the width of the beat
	function automatic logic [63:0] lane_data(logic [63:0] d, logic [1:0] sz);
		case (sz)
			SZ_BYTE: return {56'h0, d[7:0]};
			SZ_HALF: return {48'h0, d[15:0]};
			SZ_WORD: return {32'h0, d[31:0]};
			default: return d;
		endcase
	endfunction

	// shift k such that the mask is all ones shifted right by k, or -1
	function automatic int mask_to_shift(logic [31:0] m);
		for (int k = 0; k < 32; k++)
			if (m == (32'hFFFF_FFFF >> k))
				return k;
		return -1;
	endfunction

	// route one access through the shadow table
	task automatic decode_access();
		int          pg;
		logic        blk;
		logic [4:0]  h;
		logic [4:0]  sh;
		logic [31:0] base;
		logic [31:0] off;
		logic [31:0] phys;
		logic [63:0] wd;
		pg   = address[31:24];
		blk  = 1'b0;
		h    = 5'd0;
		sh   = 5'd0;
		base = 32'd0;
		wd   = is_write ? write_data : 64'h0;
		if (pg < PAGE_ENTRIES) begin
			blk  = map_blk[pg];
			h    = map_hnd[pg];
			base = map_base[pg];
			sh   = map_shift[pg];
		end
		if (!blk) begin
			// handler page: a double goes out as two 32-bit words
			if (access_size == SZ_DOUBLE) begin
				push_word(ST_OK, ROUTE_HANDLER, h, address, SZ_WORD,
					{32'h0, wd[31:0]}, is_write, 1'b0);
				push_word(ST_OK, ROUTE_HANDLER, h, address + 32'd4, SZ_WORD,
					{32'h0, wd[63:32]}, is_write, 1'b1);
			end else begin
				push_word(ST_OK, ROUTE_HANDLER, h, address, access_size,
					lane_data(wd, access_size), is_write, 1'b1);
			end
		end else begin
			// direct page: wrap the offset, then swap byte lanes on a big-endian host
			off = address & (32'hFFFF_FFFF >> sh);
			if (be_host && access_size == SZ_BYTE)
				off ^= 32'd3;
			else if (be_host && access_size == SZ_HALF)
				off ^= 32'd2;
			phys = base + off;
			if (access_size == SZ_DOUBLE && split64) begin
				push_word(ST_OK, ROUTE_DIRECT, 5'd0, phys, SZ_WORD,
					{32'h0, wd[31:0]}, is_write, 1'b0);
				push_word(ST_OK, ROUTE_DIRECT, 5'd0, phys + 32'd4, SZ_WORD,
					{32'h0, wd[63:32]}, is_write, 1'b1);
			end else begin
				push_word(ST_OK, ROUTE_DIRECT, 5'd0, phys, access_size,
					lane_data(wd, access_size), is_write, 1'b1);
			end
		end
	endtask

	// fill a page range with a handler slot
	task automatic fill_handler(output logic [1:0] st);
		if (first_page > last_page || last_page >= PAGE_ENTRIES
				|| handler_number >= HANDLER_SLOTS) begin
			st = ST_BAD_RANGE;
		end else begin
			for (int i = first_page; i <= last_page; i++) begin
				map_blk[i]   = 1'b0;
				map_base[i]  = 32'd0;
				map_shift[i] = 5'd0;
				map_hnd[i]   = handler_number;
			end
			st = ST_OK;
		end
	endtask

	// fill a page range with a direct block, base stepping one page each
	task automatic fill_block(output logic [1:0] st);
		int          k;
		logic [31:0] b;
		k = mask_to_shift(address_mask);
		b = block_base;
		if (first_page > last_page || last_page >= PAGE_ENTRIES) begin
			st = ST_BAD_RANGE;
		end else if (block_base == 32'd0 || block_base[7:0] != 8'd0) begin
			st = ST_BAD_BASE;
		end else if (k < 0) begin
			st = ST_BAD_MASK;
		end else begin
			for (int i = first_page; i <= last_page; i++) begin
				map_blk[i]   = 1'b1;
				map_base[i]  = b;
				map_shift[i] = 5'(k);
				map_hnd[i]   = 5'd0;
				b += PAGE_STEP;
			end
			st = ST_OK;
		end
	endtask

	// copy entries one at a time, destination wrapping around the table
	task automatic copy_pages(output logic [1:0] st);
		int fst;
		int cnt;
		int dst;
		int stop;
		int dpg;
		int spg;
		fst  = first_page;
		cnt  = page_count;
		dst  = dest_page;
		stop = fst + cnt - 1;
		if (cnt == 0 || fst >= PAGE_ENTRIES || dst >= PAGE_ENTRIES || stop >= PAGE_ENTRIES
				|| (dst >= fst && dst <= stop)) begin
			st = ST_BAD_RANGE;
		end else begin
			for (int i = 0; i < cnt; i++) begin
				dpg = (dst + i) % PAGE_ENTRIES;
				spg = fst + i;
				map_blk[dpg]   = map_blk[spg];
				map_base[dpg]  = map_base[spg];
				map_shift[dpg] = map_shift[spg];
				map_hnd[dpg]   = map_hnd[spg];
			end
			st = ST_OK;
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// configuration, result compare, then prediction of the accepted word
	always @(posedge clk or negedge arst_n) begin
		word_t      want;
		logic [1:0] st;
		if (!arst_n) begin
			for (int i = 0; i < PAGE_ENTRIES; i++) begin
				map_blk[i]   = 1'b0;
				map_base[i]  = 32'd0;
				map_shift[i] = 5'd0;
				map_hnd[i]   = 5'd0;
			end
			be_host = 1'b1;
			split64 = 1'b0;
			word_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == CFG_BIG_ENDIAN)
					be_host = cfg_data;
				else if (cfg_index == CFG_SPLIT_64)
					split64 = cfg_data;
			end

			if (result_strobe) begin
				if (word_q.size() == 0) begin
					$error("result word with nothing expected");
					mismatches++;
				end else begin
					want = word_q.pop_front();
					check_field("status", want.status, status);
					check_field("route", want.route, route);
					check_field("handler_out", want.hnd, handler_out);
					check_field("target_address", want.addr, target_address);
					check_field("beat_size", want.size, beat_size);
					check_field("beat_data", want.data, beat_data);
					check_field("beat_write", want.wr, beat_write);
					check_field("last", want.last, last);
					words_checked++;
				end
			end

			if (start && !busy) begin
				if (command == CMD_ACCESS) begin
					decode_access();
				end else begin
					case (command)
						CMD_MAP_HANDLR: fill_handler(st);
						CMD_MAP_BLOCK:  fill_block(st);
						default:        copy_pages(st);
					endcase
					push_word(st, ROUTE_HANDLER, 5'd0, 32'd0, SZ_BYTE, 64'd0, 1'b0, 1'b1);
				end
			end
			outstanding <= word_q.size();
		end
	end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the page map address decoder: a directed set of accesses,
// map and mirror commands, then random traffic in bursts over several
// configuration settings; the checker predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pmad_pkg::*;

	localparam int PHASE_ITEMS = 120;
	localparam int PHASES      = 5;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  command;
	logic [31:0] address;
	logic [1:0]  access_size;
	logic        is_write;
	logic [63:0] write_data;
	logic [7:0]  first_page;
	logic [7:0]  last_page;
	logic [8:0]  page_count;
	logic [7:0]  dest_page;
	logic [4:0]  handler_number;
	logic [31:0] block_base;
	logic [31:0] address_mask;
	logic        cfg_write;
	logic [CFG_IW-1:0] cfg_index;
	logic        cfg_data;
	logic        result_strobe;
	logic [1:0]  status;
	logic        route;
	logic [4:0]  handler_out;
	logic [31:0] target_address;
	logic [1:0]  beat_size;
	logic [63:0] beat_data;
	logic        beat_write;
	logic        last;
	int          mismatches;
	int          outstanding;
	int          words_checked;

	// one command word as driven on the input ports
	typedef struct {
		logic [1:0]  command;
		logic [31:0] address;
		logic [1:0]  access_size;
		logic        is_write;
		logic [63:0] write_data;
		logic [7:0]  first_page;
		logic [7:0]  last_page;
		logic [8:0]  page_count;
		logic [7:0]  dest_page;
		logic [4:0]  handler_number;
		logic [31:0] block_base;
		logic [31:0] address_mask;
	} req_t;

	int   burst_left;
	int   sent_by_cmd [4];
	req_t plan[$];

	page_map_address_decoder_unit dut (.*);

	pmad_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// every field random; builders below overwrite what matters
	function automatic req_t noise();
		req_t r;
		r.command        = 2'($urandom_range(0, 3));
		r.address        = $urandom;
		r.access_size    = 2'($urandom_range(0, 3));
		r.is_write       = 1'($urandom_range(0, 1));
		r.write_data     = {$urandom, $urandom};
		r.first_page     = 8'($urandom_range(0, 255));
		r.last_page      = 8'($urandom_range(0, 255));
		r.page_count     = 9'($urandom_range(0, 511));
		r.dest_page      = 8'($urandom_range(0, 255));
		r.handler_number = 5'($urandom_range(0, 31));
		r.block_base     = $urandom;
		r.address_mask   = $urandom;
		return r;
	endfunction

	function automatic req_t mk_access(logic [31:0] a, logic [1:0] sz, logic wr,
			logic [63:0] d);
		req_t r;
		r = noise();
		r.command     = CMD_ACCESS;
		r.address     = a;
		r.access_size = sz;
		r.is_write    = wr;
		r.write_data  = d;
		return r;
	endfunction

	function automatic req_t mk_map_handler(int fp, int lp, int h);
		req_t r;
		r = noise();
		r.command        = CMD_MAP_HANDLR;
		r.first_page     = 8'(fp);
		r.last_page      = 8'(lp);
		r.handler_number = 5'(h);
		return r;
	endfunction

	function automatic req_t mk_map_block(int fp, int lp, logic [31:0] b, logic [31:0] m);
		req_t r;
		r = noise();
		r.command      = CMD_MAP_BLOCK;
		r.first_page   = 8'(fp);
		r.last_page    = 8'(lp);
		r.block_base   = b;
		r.address_mask = m;
		return r;
	endfunction

	function automatic req_t mk_mirror(int dp, int fp, int cnt);
		req_t r;
		r = noise();
		r.command    = CMD_MIRROR;
		r.dest_page  = 8'(dp);
		r.first_page = 8'(fp);
		r.page_count = 9'(cnt);
		return r;
	endfunction

	// mostly well-formed commands with small ranges, some broken ones
	function automatic req_t random_req();
		req_t        r;
		int          sel;
		int          fp;
		int          lp;
		int          span;
		int          cnt;
		int          dp;
		logic [31:0] b;
		sel  = $urandom_range(0, 99);
		fp   = $urandom_range(0, 255);
		span = ($urandom_range(0, 31) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
		lp   = (fp + span > 255) ? 255 : fp + span;
		if (sel < 60) begin
			r = noise();
			r.command = CMD_ACCESS;
		end else if (sel < 75) begin
			if ($urandom_range(0, 7) == 0) begin
				fp = $urandom_range(1, 255);
				lp = $urandom_range(0, fp - 1);
			end
			r = mk_map_handler(fp, lp, $urandom_range(0, 31));
		end else if (sel < 90) begin
			b = $urandom & 32'hFFFF_FF00;
			if (b == 32'd0)
				b = PAGE_STEP;
			r = mk_map_block(fp, lp, b, 32'hFFFF_FFFF >> $urandom_range(0, 31));
			if ($urandom_range(0, 4) == 0) begin
				case ($urandom_range(0, 4))
					0: begin
						r.first_page = 8'($urandom_range(1, 255));
						r.last_page  = 8'($urandom_range(0, r.first_page - 1));
					end
					1: r.block_base = 32'd0;
					2: r.block_base = b | $urandom_range(1, 255);
					3: r.address_mask = $urandom;
					default: r.address_mask = 32'd0;
				endcase
			end
		end else begin
			cnt = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
			fp  = $urandom_range(0, 256 - cnt);
			do
				dp = $urandom_range(0, 255);
			while (dp >= fp && dp <= fp + cnt - 1);
			if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 2))
					0: cnt = 0;
					1: dp = $urandom_range(fp, fp + cnt - 1);
					default: cnt = $urandom_range(257 - fp, 511);
				endcase
			end
			r = mk_mirror(dp, fp, cnt);
		end
		return r;
	endfunction

	// hold start until the block takes the word
	task automatic issue(input req_t r);
		start          <= 1'b1;
		command        <= r.command;
		address        <= r.address;
		access_size    <= r.access_size;
		is_write       <= r.is_write;
		write_data     <= r.write_data;
		first_page     <= r.first_page;
		last_page      <= r.last_page;
		page_count     <= r.page_count;
		dest_page      <= r.dest_page;
		handler_number <= r.handler_number;
		block_base     <= r.block_base;
		address_mask   <= r.address_mask;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sent_by_cmd[r.command]++;
	endtask

	// bursts of random length separated by random gaps
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
				: $urandom_range(0, 12);
		end
	endtask

	// stop sending and wait for every predicted word
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic set_config(input logic be, input logic split);
		drain();
		repeat (4) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= CFG_BIG_ENDIAN;
		cfg_data  <= be;
		@(posedge clk);
		cfg_index <= CFG_SPLIT_64;
		cfg_data  <= split;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// stimulus and verdict
	initial begin
		logic be;
		logic split;
		arst_n         <= 1'b0;
		start          <= 1'b0;
		command        <= CMD_ACCESS;
		address        <= 32'd0;
		access_size    <= SZ_BYTE;
		is_write       <= 1'b0;
		write_data     <= 64'd0;
		first_page     <= 8'd0;
		last_page      <= 8'd0;
		page_count     <= 9'd0;
		dest_page      <= 8'd0;
		handler_number <= 5'd0;
		block_base     <= 32'd0;
		address_mask   <= 32'd0;
		cfg_write      <= 1'b0;
		cfg_index      <= CFG_BIG_ENDIAN;
		cfg_data       <= 1'b0;
		burst_left = 0;
		foreach (sent_by_cmd[i])
			sent_by_cmd[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// handler pages after reset, high word of a double wrapping past the top
		plan.push_back(mk_access(32'h0000_0000, SZ_BYTE, 1'b0, 64'h0));
		plan.push_back(mk_access(32'hFFFF_FFFC, SZ_DOUBLE, 1'b1, 64'h0123_4567_89AB_CDEF));
		plan.push_back(mk_map_handler(8'h10, 8'h1F, 31));
		plan.push_back(mk_access(32'h1A34_5679, SZ_HALF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
		plan.push_back(mk_map_handler(8'h20, 8'h1F, 3));
		plan.push_back(mk_map_handler(0, 255, 0));
		// block bases wrapping past the top, bad bases and masks, range error first
		plan.push_back(mk_map_block(8'h80, 8'h8F, 32'hFF00_0000, 32'h00FF_FFFF));
		plan.push_back(mk_map_block(8'h90, 8'h90, 32'h0000_0000, 32'h0000_FFFF));
		plan.push_back(mk_map_block(8'h90, 8'h90, 32'h0000_1080, 32'h0000_FFFF));
		plan.push_back(mk_map_block(8'h90, 8'h90, 32'h1000_0000, 32'h0F0F_0F0F));
		plan.push_back(mk_map_block(8'h90, 8'h90, 32'h1000_0000, 32'h0000_0000));
		plan.push_back(mk_map_block(8'h91, 8'h90, 32'h0000_0001, 32'h0000_000E));
		plan.push_back(mk_map_block(8'h40, 8'h40, 32'h0000_0100, 32'hFFFF_FFFF));
		plan.push_back(mk_map_block(8'h41, 8'h41, 32'hFFFF_FF00, 32'h0000_0001));
		// direct accesses of every width with byte lane swap
		plan.push_back(mk_access(32'h8012_3456, SZ_BYTE, 1'b1, 64'hFFFF_FFFF_FFFF_FFA5));
		plan.push_back(mk_access(32'h8112_3457, SZ_HALF, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF));
		plan.push_back(mk_access(32'h40FF_FFFF, SZ_WORD, 1'b1, 64'hDEAD_BEEF_CAFE_F00D));
		plan.push_back(mk_access(32'h41FF_FFFE, SZ_DOUBLE, 1'b1, 64'h8000_0001_7FFF_FFFE));
		// mirrors: wrapping destination, overlapping copy, and the error cases
		plan.push_back(mk_mirror(8'hF8, 8'h80, 16));
		plan.push_back(mk_mirror(8'h7C, 8'h80, 8));
		plan.push_back(mk_mirror(8'h10, 8'h10, 4));
		plan.push_back(mk_mirror(8'h00, 8'h10, 0));
		plan.push_back(mk_mirror(8'h00, 8'hF0, 17));
		plan.push_back(mk_mirror(8'h50, 8'h00, 300));
		plan.push_back(mk_access(32'h0312_3455, SZ_DOUBLE, 1'b0, 64'h0));
		foreach (plan[i]) begin
			issue(plan[i]);
			pace();
		end

		// random traffic over several configuration settings, extremes included
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin be = 1'b0; split = 1'b1; end
				1: begin be = 1'b1; split = 1'b1; end
				2: begin be = 1'b0; split = 1'b0; end
				3: begin be = 1'($urandom_range(0, 1)); split = 1'($urandom_range(0, 1)); end
				default: begin be = 1'b1; split = 1'b0; end
			endcase
			set_config(be, split);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				issue(random_req());
				pace();
			end
		end

		drain();
		repeat (10) @(posedge clk);
		$display("sent %0d accesses, %0d handler maps, %0d block maps, %0d mirrors",
			sent_by_cmd[CMD_ACCESS], sent_by_cmd[CMD_MAP_HANDLR],
			sent_by_cmd[CMD_MAP_BLOCK], sent_by_cmd[CMD_MIRROR]);
		$display("%0d result words checked over %0d configuration settings",
			words_checked, PHASES + 1);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
